### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the LED PWM controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge once reset has been released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/rlpc_pkg.sv
// ----------------------------------------------------------------------------
// rlpc_pkg
// Types, constants and helpers shared by the LED PWM controller modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlpc_pkg;

  localparam int NUM_LEDS   = 3;
  localparam int LED_SLOTS  = 3;
  localparam int LEVEL_W    = 7;
  localparam int DELAY_W    = 34;

  localparam logic [6:0]  LEVEL_MAX   = 7'd100;
  localparam logic [6:0]  PWM_LAST    = 7'd99;
  localparam logic [33:0] DELAY_RESET = 34'd100000;

  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_ONE  = 8'd49;
  localparam logic [7:0] CH_NINE = 8'd57;

  typedef enum logic [2:0] {
    STS_TICK      = 3'd0,
    STS_OK        = 3'd1,
    STS_BAD_LED   = 3'd2,
    STS_BAD_MODE  = 3'd3,
    STS_BAD_DIGIT = 3'd4
  } status_t;

  // Decoded command, handed from the decoder to the state update.
  typedef struct packed {
    status_t                status;
    logic [LED_SLOTS-1:0]   led_mask;
    logic                   set_level;
    logic [LEVEL_W-1:0]     level;
    logic                   set_effect;
    logic                   effect_on;
    logic                   set_delay;
    logic [DELAY_W-1:0]     delay;
  } cmd_t;

  function automatic logic [DELAY_W-1:0] pow10(input logic [3:0] e);
    logic [DELAY_W-1:0] p;
    case (e)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/rlpc_cmd_dec.sv
// ----------------------------------------------------------------------------
// rlpc_cmd_dec
// Decodes one four-byte ASCII command into a LED mask and the update it asks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlpc_cmd_dec (
  input  logic [7:0]     cmd_led,
  input  logic [7:0]     cmd_mode,
  input  logic [7:0]     cmd_arg1,
  input  logic [7:0]     cmd_arg2,
  output rlpc_pkg::cmd_t cmd
);
  import rlpc_pkg::*;

  logic                 led_ok;
  logic [LED_SLOTS-1:0] mask;
  logic                 a1_dig;
  logic                 a2_dig;
  logic [3:0]           d1;
  logic [3:0]           d2;
  logic [37:0]          prod;
  logic [7:0]           lvl;
  logic [7:0]           hund;

  assign a1_dig = (cmd_arg1 >= CH_ZERO) && (cmd_arg1 <= CH_NINE);
  assign a2_dig = (cmd_arg2 >= CH_ZERO) && (cmd_arg2 <= CH_NINE);
  assign d1     = cmd_arg1[3:0];
  assign d2     = cmd_arg2[3:0];

  // mantissa times 10^exponent, kept to the delay width
  assign prod = {4'b0, pow10(d2)} * {34'b0, d1};

  assign hund = cmd_mode[0] ? 8'd100 : 8'd0;
  assign lvl  = hund + {1'b0, d1, 3'b0} + {3'b0, d1, 1'b0} + {4'b0, d2};

  always_comb begin
    mask   = '0;
    led_ok = 1'b1;
    case (cmd_led)
      CH_R:    mask[0] = 1'b1;
      CH_G:    mask[1] = 1'b1;
      CH_B:    mask[2] = 1'b1;
      CH_A:    mask    = '1;
      default: led_ok  = 1'b0;
    endcase
    // drop slots that are not fitted; a single unfitted LED is a bad letter
    for (int i = 0; i < LED_SLOTS; i++) begin
      if (i >= NUM_LEDS) begin
        if (mask[i] && (cmd_led != CH_A)) led_ok = 1'b0;
        mask[i] = 1'b0;
      end
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.led_mask   = mask;
    cmd.level      = (lvl > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : lvl[6:0];
    cmd.effect_on  = (cmd_arg1 == CH_N);
    cmd.delay      = prod[33:0];
    cmd.status     = STS_OK;
    if (!led_ok) begin
      cmd.status = STS_BAD_LED;
    end else if (cmd_mode == CH_E) begin
      if ((cmd_arg1 == CH_N) || (cmd_arg1 == CH_F)) begin
        cmd.set_effect = 1'b1;
      end else if (a1_dig && a2_dig) begin
        cmd.set_delay = 1'b1;
      end else begin
        cmd.status = STS_BAD_DIGIT;
      end
    end else if ((cmd_mode == CH_ZERO) || (cmd_mode == CH_ONE)) begin
      if (a1_dig && a2_dig) begin
        cmd.set_level = 1'b1;
      end else begin
        cmd.status = STS_BAD_DIGIT;
      end
    end else begin
      cmd.status = STS_BAD_MODE;
    end
  end

endmodule

### rtl/core/rgb_led_pwm_command_controller_unit.sv
// ----------------------------------------------------------------------------
// rgb_led_pwm_command_controller_unit
// Three-channel LED PWM controller driven by ticks and ASCII commands.
// ----------------------------------------------------------------------------
// Pipeline: input word register, then result register; state updates as the
//   word leaves the input register, at the same edge that loads the result
//   register, and a result that is not taken holds the word in the input register.
// Throughput: one word per cycle while results are taken, set by the single-pass update of the state.
// While a result waits, an empty input register still takes one word; then
//   in_ready drops until the result is taken.
// Reset (rst_n low, synchronous): levels 0, effects off, delay 100000,
//   ramp at 0 rising, PWM counter and wait counter 0, both stages empty.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rgb_led_pwm_command_controller_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_cmd_led,
  input  logic [7:0] in_cmd_mode,
  input  logic [7:0] in_cmd_arg1,
  input  logic [7:0] in_cmd_arg2,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_red_on,
  output logic       out_green_on,
  output logic       out_blue_on,
  output logic [2:0] out_status
);
  import rlpc_pkg::*;

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } find_t;

  // First enabled, fitted LED at or after 'from'.
  function automatic find_t find_enabled(input logic [LED_SLOTS-1:0] en,
                                         input logic [1:0] from);
    find_t f;
    f = '0;
    for (int i = LED_SLOTS - 1; i >= 0; i--) begin
      if ((i >= int'(from)) && (i < NUM_LEDS) && en[i]) begin
        f.found = 1'b1;
        f.idx   = 2'(i);
      end
    end
    return f;
  endfunction

  // Input word register
  logic       in_vld_r;
  logic       func_r;
  logic [7:0] led_r;
  logic [7:0] mode_r;
  logic [7:0] arg1_r;
  logic [7:0] arg2_r;

  // Result register
  logic       out_vld_r;
  logic       red_r;
  logic       green_r;
  logic       blue_r;
  status_t    status_r;

  // Controller state
  logic [6:0]                         pwm_count_r, pwm_count_nxt;
  logic [LED_SLOTS-1:0][LEVEL_W-1:0]  led_level_r, led_level_nxt;
  logic [LED_SLOTS-1:0]               effect_en_r, effect_en_nxt;
  logic [DELAY_W-1:0]                 delay_r, delay_nxt;
  logic [6:0]                         ramp_level_r, ramp_level_nxt;
  logic                               ramp_fall_r, ramp_fall_nxt;
  logic [1:0]                         ramp_led_r, ramp_led_nxt;
  logic [DELAY_W-1:0]                 wait_left_r, wait_left_nxt;

  logic                 advance;
  cmd_t                 cmd;
  find_t                hit_cur;
  find_t                hit_first;
  logic [6:0]           step_level;
  logic                 step_fall;
  logic [LED_SLOTS-1:0] drive;
  status_t              status_nxt;

  // Move the held word forward when the result slot is free or draining.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  rlpc_cmd_dec u_cmd_dec (
    .cmd_led  (led_r),
    .cmd_mode (mode_r),
    .cmd_arg1 (arg1_r),
    .cmd_arg2 (arg2_r),
    .cmd      (cmd)
  );

  assign hit_cur   = find_enabled(effect_en_r, ramp_led_r);
  assign hit_first = find_enabled(effect_en_r, 2'd0);

  // One step of the triangle ramp: hold at the ends while turning around.
  always_comb begin
    step_level = ramp_level_r;
    step_fall  = ramp_fall_r;
    if (!ramp_fall_r) begin
      if (ramp_level_r >= LEVEL_MAX) step_fall = 1'b1;
      else step_level = ramp_level_r + 7'd1;
    end else begin
      if (ramp_level_r == 7'd0) step_fall = 1'b0;
      else step_level = ramp_level_r - 7'd1;
    end
  end

  always_comb begin
    pwm_count_nxt  = pwm_count_r;
    led_level_nxt  = led_level_r;
    effect_en_nxt  = effect_en_r;
    delay_nxt      = delay_r;
    ramp_level_nxt = ramp_level_r;
    ramp_fall_nxt  = ramp_fall_r;
    ramp_led_nxt   = ramp_led_r;
    wait_left_nxt  = wait_left_r;
    status_nxt     = STS_TICK;

    if (!func_r) begin
      // tick: count down the wait, or let the ramp write the next LED
      if (wait_left_r != '0) begin
        wait_left_nxt = wait_left_r - 34'd1;
      end else if (hit_cur.found) begin
        led_level_nxt[hit_cur.idx] = ramp_level_r;
        ramp_led_nxt               = 2'(hit_cur.idx + 2'd1);
        wait_left_nxt              = delay_r;
      end else if (hit_first.found) begin
        ramp_level_nxt               = step_level;
        ramp_fall_nxt                = step_fall;
        led_level_nxt[hit_first.idx] = step_level;
        ramp_led_nxt                 = 2'(hit_first.idx + 2'd1);
        wait_left_nxt                = delay_r;
      end
      pwm_count_nxt = (pwm_count_r == PWM_LAST) ? 7'd0 : pwm_count_r + 7'd1;
    end else begin
      status_nxt = cmd.status;
      for (int i = 0; i < LED_SLOTS; i++) begin
        if (cmd.led_mask[i]) begin
          if (cmd.set_level)  led_level_nxt[i] = cmd.level;
          if (cmd.set_effect) effect_en_nxt[i] = cmd.effect_on;
        end
      end
      if (cmd.set_delay) delay_nxt = cmd.delay;
    end

    // compare the phase before the counter moves with the updated levels
    for (int i = 0; i < LED_SLOTS; i++) begin
      drive[i] = (i < NUM_LEDS) && (pwm_count_r < led_level_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      pwm_count_r  <= '0;
      led_level_r  <= '0;
      effect_en_r  <= '0;
      delay_r      <= DELAY_RESET;
      ramp_level_r <= '0;
      ramp_fall_r  <= 1'b0;
      ramp_led_r   <= '0;
      wait_left_r  <= '0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (advance) begin
        out_vld_r    <= 1'b1;
        pwm_count_r  <= pwm_count_nxt;
        led_level_r  <= led_level_nxt;
        effect_en_r  <= effect_en_nxt;
        delay_r      <= delay_nxt;
        ramp_level_r <= ramp_level_nxt;
        ramp_fall_r  <= ramp_fall_nxt;
        ramp_led_r   <= ramp_led_nxt;
        wait_left_r  <= wait_left_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers: load on accept / advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      led_r  <= in_cmd_led;
      mode_r <= in_cmd_mode;
      arg1_r <= in_cmd_arg1;
      arg2_r <= in_cmd_arg2;
    end
    if (advance) begin
      red_r    <= drive[0];
      green_r  <= drive[1];
      blue_r   <= drive[2];
      status_r <= status_nxt;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_red_on   = red_r;
  assign out_green_on = green_r;
  assign out_blue_on  = blue_r;
  assign out_status   = status_r;

  `ASSERT_CLK(a_pwm_range, clk, rst_n, pwm_count_r <= PWM_LAST, "pwm counter out of range")
  `ASSERT_CLK(a_ramp_range, clk, rst_n, ramp_level_r <= LEVEL_MAX, "ramp level above max")
  `ASSERT_CLK(a_ramp_led, clk, rst_n, ramp_led_r <= 2'(NUM_LEDS), "ramp LED index too large")
  `ASSERT_CLK(a_stall_blocks, clk, rst_n, (in_vld_r && out_vld_r && !out_ready) |-> !in_ready, "input taken while both stages blocked")
  `ASSERT_CLK(a_no_wait_idle, clk, rst_n, (effect_en_r == '0 && wait_left_r == '0 && advance && !func_r) |=> (wait_left_r == '0), "wait loaded with no effect enabled")

endmodule

### tb/rgb_led_pwm_command_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// rgb_led_pwm_command_controller_unit_tb
// Checks every result word of the LED PWM controller against a cycle-free
// predictor of the PWM counter, the fixed levels, the breathing ramp and the
// command decoder. Directed words come first, then random ticks and commands
// under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_led_pwm_command_controller_unit_tb;
  import rlpc_pkg::*;

  // Generous bound: ~1100 words, each at worst waiting out a choked receiver.
  localparam int CYCLE_LIMIT  = 400000;
  // Two-stage pipeline; give it a few extra cycles to show a stray word.
  localparam int DRAIN_CYCLES = 8;

  // One expected result word.
  typedef struct packed {
    logic    red;
    logic    green;
    logic    blue;
    status_t status;
  } led_drive_t;

  // Receiver stall patterns, picked per segment.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_CHOKED
  } rx_pattern_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_func;
  logic [7:0] in_cmd_led;
  logic [7:0] in_cmd_mode;
  logic [7:0] in_cmd_arg1;
  logic [7:0] in_cmd_arg2;
  logic       out_valid;
  logic       out_ready;
  logic       out_red_on;
  logic       out_green_on;
  logic       out_blue_on;
  logic [2:0] out_status;

  rgb_led_pwm_command_controller_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_cmd_led   (in_cmd_led),
    .in_cmd_mode  (in_cmd_mode),
    .in_cmd_arg1  (in_cmd_arg1),
    .in_cmd_arg2  (in_cmd_arg2),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_on   (out_red_on),
    .out_green_on (out_green_on),
    .out_blue_on  (out_blue_on),
    .out_status   (out_status)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of everything the block remembers.
  // --------------------------------------------------------------------------
  logic [LEVEL_W-1:0] pwm_cnt;
  logic [LEVEL_W-1:0] duty [LED_SLOTS];
  logic               breathe_on [LED_SLOTS];
  logic [DELAY_W-1:0] breathe_delay;
  logic [LEVEL_W-1:0] ramp_duty;
  logic               ramp_down;
  int                 ramp_next;
  logic [DELAY_W-1:0] hold_ticks;

  led_drive_t expected_drive [$];
  int         mismatches  = 0;
  int         cycle_count = 0;
  int         burst_left  = 0;

  // Clock: 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Index of the first LED at or after 'from' whose breathing is on, or -1.
  function automatic int first_breathing(input int from);
    for (int k = from; k < NUM_LEDS && k < LED_SLOTS; k++)
      if (breathe_on[k]) return k;
    return -1;
  endfunction

  // Advance the predictor by one accepted word and return the result word
  // that the block must produce for it.
  function automatic led_drive_t apply_word(input logic func, input logic [7:0] sel,
                                            input logic [7:0] mode, input logic [7:0] a1,
                                            input logic [7:0] a2);
    led_drive_t           r;
    logic [LED_SLOTS-1:0] lit;
    logic [LEVEL_W-1:0]   phase;
    logic [63:0]          span;
    int                   lo, hi, k, lvl;
    logic                 a1_dig, a2_dig;
    phase  = pwm_cnt;
    a1_dig = (a1 >= CH_ZERO) && (a1 <= CH_NINE);
    a2_dig = (a2 >= CH_ZERO) && (a2 <= CH_NINE);
    if (!func) begin
      r.status = STS_TICK;
      // Burn down a running wait first; only an expired wait lets the ramp write.
      if (hold_ticks != 0) begin
        hold_ticks = hold_ticks - 34'd1;
      end else if (first_breathing(0) >= 0) begin
        k = first_breathing(ramp_next);
        if (k < 0) begin
          // Wrapped past the last breathing LED: step the triangle once.
          // At either end the direction turns and the level is held.
          if (!ramp_down) begin
            if (ramp_duty >= LEVEL_MAX) ramp_down = 1'b1;
            else ramp_duty = ramp_duty + 7'd1;
          end else begin
            if (ramp_duty == 0) ramp_down = 1'b0;
            else ramp_duty = ramp_duty - 7'd1;
          end
          k = first_breathing(0);
        end
        duty[k]    = ramp_duty;
        ramp_next  = k + 1;
        hold_ticks = breathe_delay;
      end
      pwm_cnt = (pwm_cnt == PWM_LAST) ? 7'd0 : pwm_cnt + 7'd1;
    end else begin
      // Unknown letters map past the last slot so they fail the range test.
      case (sel)
        CH_R:    begin lo = 0; hi = 0; end
        CH_G:    begin lo = 1; hi = 1; end
        CH_B:    begin lo = 2; hi = 2; end
        CH_A:    begin lo = 0; hi = (NUM_LEDS < LED_SLOTS) ? NUM_LEDS - 1 : LED_SLOTS - 1; end
        default: begin lo = LED_SLOTS; hi = LED_SLOTS; end
      endcase
      if (lo >= NUM_LEDS) begin
        r.status = STS_BAD_LED;
      end else if (mode == CH_E) begin
        if (a1 == CH_N || a1 == CH_F) begin
          // Second argument byte is don't-care for on/off.
          for (k = lo; k <= hi; k++) breathe_on[k] = (a1 == CH_N);
          r.status = STS_OK;
        end else if (!(a1_dig && a2_dig)) begin
          r.status = STS_BAD_DIGIT;
        end else begin
          // Delay is mantissa times ten to the exponent; a running wait keeps going.
          span = 64'(a1 - CH_ZERO);
          repeat (a2 - CH_ZERO) span = span * 10;
          breathe_delay = span[DELAY_W-1:0];
          r.status      = STS_OK;
        end
      end else if (mode == CH_ZERO || mode == CH_ONE) begin
        if (!(a1_dig && a2_dig)) begin
          r.status = STS_BAD_DIGIT;
        end else begin
          lvl = 100 * int'(mode - CH_ZERO) + 10 * int'(a1 - CH_ZERO) + int'(a2 - CH_ZERO);
          if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
          for (k = lo; k <= hi; k++) duty[k] = lvl[LEVEL_W-1:0];
          r.status = STS_OK;
        end
      end else begin
        r.status = STS_BAD_MODE;
      end
    end
    // Commands compare against the phase of the next tick; ticks use the
    // phase before the counter advanced.
    for (k = 0; k < LED_SLOTS; k++) lit[k] = (k < NUM_LEDS) && (phase < duty[k]);
    r.red   = lit[0];
    r.green = lit[1];
    r.blue  = lit[2];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: drive at the falling edge, hold until accepted, then predict.
  // Words go out in bursts; a burst is either preceded by a short gap or is a
  // long steady stretch with no gap at all.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic func, input logic [7:0] sel, input logic [7:0] mode,
                           input logic [7:0] a1, input logic [7:0] a2);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(24, 80);
      end else begin
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
        burst_left = $urandom_range(1, 12);
      end
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_func     <= func;
    in_cmd_led  <= sel;
    in_cmd_mode <= mode;
    in_cmd_arg1 <= a1;
    in_cmd_arg2 <= a2;
    do @(posedge clk); while (!in_ready);
    expected_drive.push_back(apply_word(func, sel, mode, a1, a2));
    burst_left--;
  endtask

  // Ticks carry random bytes so the unused fields still toggle.
  task automatic send_tick();
    send_word(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_cmd(input logic [7:0] sel, input logic [7:0] mode,
                          input logic [7:0] a1, input logic [7:0] a2);
    send_word(1'b1, sel, mode, a1, a2);
  endtask

  function automatic logic [7:0] dig(input int n);
    return CH_ZERO + 8'(n);
  endfunction

  function automatic logic [7:0] pick_led();
    case ($urandom_range(0, 3))
      0:       return CH_R;
      1:       return CH_G;
      2:       return CH_B;
      default: return CH_A;
    endcase
  endfunction

  // Well-formed level command; hundreds digit '1' is rarer to keep levels varied.
  task automatic send_random_level();
    send_cmd(pick_led(), ($urandom_range(0, 4) == 0) ? CH_ONE : CH_ZERO,
             dig($urandom_range(0, 9)), dig($urandom_range(0, 9)));
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Fixed levels: full, half, clamp above 100, all-LED write, minimum.
  task automatic test_fixed_levels();
    send_cmd(CH_R, CH_ONE, CH_ZERO, CH_ZERO);
    send_cmd(CH_G, CH_ZERO, dig(5), dig(0));
    send_cmd(CH_B, CH_ONE, CH_NINE, CH_NINE);
    send_tick();
    send_tick();
    send_cmd(CH_A, CH_ZERO, CH_ZERO, CH_ZERO);
    send_cmd(CH_A, CH_ZERO, CH_ZERO, dig(1));
    send_tick();
  endtask

  // Rejections: bad LED letter, bad mode, non-digit bytes at the digit edges.
  task automatic test_rejected_commands();
    send_cmd(8'h00, CH_ZERO, dig(5), dig(5));
    send_cmd(8'hFF, CH_E, CH_N, dig(0));
    send_cmd(CH_R, CH_ONE + 8'd1, dig(0), dig(0));
    send_cmd(CH_G, CH_ZERO, CH_ZERO - 8'd1, dig(3));
    send_cmd(CH_B, CH_ONE, dig(0), CH_NINE + 8'd1);
    send_cmd(CH_A, CH_E, CH_NINE + 8'd1, dig(2));
    send_cmd(CH_R, CH_E, dig(3), 8'hFF);
  endtask

  // Breathing controls: largest delay while no effect runs, then zero delay,
  // effect on with a junk second byte, a fixed level over a running effect,
  // and everything off again.
  task automatic test_breathing_controls();
    send_cmd(CH_A, CH_E, CH_NINE, CH_NINE);
    send_cmd(CH_A, CH_E, CH_ZERO, CH_NINE);
    send_cmd(CH_R, CH_E, CH_N, 8'hFF);
    send_tick();
    send_tick();
    send_tick();
    send_cmd(CH_R, CH_ONE, CH_ZERO, CH_ZERO);
    send_cmd(CH_A, CH_E, CH_F, 8'h00);
    send_tick();
  endtask

  // --------------------------------------------------------------------------
  // Random tests
  // --------------------------------------------------------------------------

  // Plain PWM: random fixed levels with plenty of ticks to sweep the phase.
  task automatic test_random_pwm();
    repeat (200) begin
      if ($urandom_range(0, 99) < 22) send_random_level();
      else send_tick();
    end
  endtask

  // Breathing: first a long zero-delay run on one LED so the ramp reaches the
  // top and turns, then a free mix of on/off, short delays, levels and ticks.
  task automatic test_random_breathing();
    int roll;
    send_cmd(CH_A, CH_E, CH_F, 8'($urandom));
    send_cmd(CH_A, CH_E, CH_ZERO, CH_ZERO);
    send_cmd(CH_R, CH_E, CH_N, 8'($urandom));
    repeat (260) begin
      roll = $urandom_range(0, 99);
      if (roll < 94) send_tick();
      else send_cmd(($urandom_range(0, 1) != 0) ? CH_G : CH_B, CH_ZERO,
                    dig($urandom_range(0, 9)), dig($urandom_range(0, 9)));
    end
    repeat (390) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) send_tick();
      else if (roll < 87) send_cmd(pick_led(), CH_E, CH_N, 8'($urandom));
      else if (roll < 90) send_cmd(pick_led(), CH_E, CH_F, 8'($urandom));
      else if (roll < 95) send_cmd(pick_led(), CH_E, dig($urandom_range(0, 3)),
                                   dig(($urandom_range(0, 4) == 0) ? 1 : 0));
      else send_random_level();
    end
  endtask

  // Noise: raw random words, random bytes behind a good LED letter, near-miss
  // digits around '0' and '9', and random LED letters.
  task automatic test_random_noise();
    int          roll;
    logic [7:0]  mode;
    repeat (220) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        send_tick();
      end else if (roll < 55) begin
        send_word(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (roll < 72) begin
        send_cmd(pick_led(), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (roll < 90) begin
        case ($urandom_range(0, 2))
          0:       mode = CH_ZERO;
          1:       mode = CH_ONE;
          default: mode = CH_E;
        endcase
        send_cmd(pick_led(), mode, CH_ZERO - 8'd1 + 8'($urandom_range(0, 11)),
                 CH_ZERO - 8'd1 + 8'($urandom_range(0, 11)));
      end else begin
        send_cmd(8'($urandom), CH_ZERO, dig($urandom_range(0, 9)), dig($urandom_range(0, 9)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern chosen per segment; open segments give
  // stretches with no stalls at all.
  // --------------------------------------------------------------------------
  initial begin : rx_stall
    rx_pattern_t pat;
    int          seg_len, period, beat;
    out_ready = 1'b0;
    beat      = 0;
    forever begin
      pat     = rx_pattern_t'($urandom_range(0, 3));
      seg_len = $urandom_range(20, 200);
      period  = $urandom_range(2, 5);
      repeat (seg_len) begin
        @(negedge clk);
        case (pat)
          RX_OPEN:     out_ready <= 1'b1;
          RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_ready <= (beat % period == 0);
          default:     out_ready <= ($urandom_range(0, 15) == 0);
        endcase
        beat++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each taken result word with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    led_drive_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_drive.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        want = expected_drive.pop_front();
        if (out_red_on !== want.red) begin
          $error("red_on: expected %0d, got %0d", want.red, out_red_on);
          mismatches++;
        end
        if (out_green_on !== want.green) begin
          $error("green_on: expected %0d, got %0d", want.green, out_green_on);
          mismatches++;
        end
        if (out_blue_on !== want.blue) begin
          $error("blue_on: expected %0d, got %0d", want.blue, out_blue_on);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run as failed once the cycle counter reaches CYCLE_LIMIT, as when the block stops moving words.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Hold every input at a known value from time zero.
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = 1'b0;
    in_cmd_led  = '0;
    in_cmd_mode = '0;
    in_cmd_arg1 = '0;
    in_cmd_arg2 = '0;

    // Predictor starts from the reset state of the block.
    pwm_cnt       = '0;
    breathe_delay = DELAY_RESET;
    ramp_duty     = '0;
    ramp_down     = 1'b0;
    ramp_next     = 0;
    hold_ticks    = '0;
    for (int k = 0; k < LED_SLOTS; k++) begin
      duty[k]       = '0;
      breathe_on[k] = 1'b0;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fixed_levels();
    test_rejected_commands();
    test_breathing_controls();
    test_random_pwm();
    test_random_breathing();
    test_random_noise();

    // Drop valid after the last word, then drain the pipeline.
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
